[src/rtpf_pkg.sv]
package rtpf_pkg;

	// Data widths of the channels and of the filter state.
	localparam int SAMPLE_W = 16;
	localparam int STATE_W  = 24;
	localparam int CF_BITS  = 16;
	localparam int COEFF_W  = 18;
	localparam int RES_W    = 17;
	localparam int MODE_W   = 3;

	// The state holds samples with extra fraction bits below them.
	localparam int UP_SHIFT = STATE_W - SAMPLE_W;
	localparam int ONE_Q    = 1 << CF_BITS;

	// Shared multiplier operand widths and derived datapath widths.
	localparam int MA_W   = STATE_W + 4;
	localparam int MB_W   = CF_BITS + 3;
	localparam int PROD_W = MA_W + MB_W;
	localparam int PQ_W   = PROD_W - CF_BITS;
	localparam int SUM_W  = PQ_W + 1;
	localparam int DIFF_W = STATE_W + 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [STATE_W-1:0]  state_t;
	typedef logic        [COEFF_W-1:0]  coeff_t;
	typedef logic        [RES_W-1:0]    res_t;
	typedef logic        [MODE_W-1:0]   mode_t;
	typedef logic signed [MA_W-1:0]     mul_a_t;
	typedef logic signed [MB_W-1:0]     mul_b_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic signed [DIFF_W-1:0]   diff_t;

	// Output mode register codes.
	localparam mode_t MODE_LP     = 3'd0;
	localparam mode_t MODE_HP     = 3'd1;
	localparam mode_t MODE_BP     = 3'd2;
	localparam mode_t MODE_ALT_LP = 3'd3;
	localparam mode_t MODE_ALT_HP = 3'd4;

	// Input clamps: cutoff at 2.0 and resonance at 1.0.
	localparam coeff_t COEFF_MAX = COEFF_W'(2 * ONE_Q);
	localparam res_t   RES_MAX   = RES_W'(ONE_Q);

	// One strobe per sequencer step.
	typedef struct packed {
		logic load;
		logic mul_fb;
		logic mul_bp;
		logic mul_t;
		logic upd1;
		logic mul_d;
		logic upd2;
		logic fin;
	} ctrl_t;

	// Saturate a wide sum to the signed state range.
	function automatic state_t sat_state(sum_t v);
		logic same;
		same = (&v[SUM_W-1:STATE_W-1]) || (~|v[SUM_W-1:STATE_W-1]);
		if (same) begin
			return v[STATE_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(STATE_W-1){1'b1}}};
		end
	endfunction

	// Drop the extra fraction bits by floor and saturate to the sample range.
	function automatic sample_t to_sample(diff_t v);
		diff_t sh;
		logic  same;
		sh = v >>> UP_SHIFT;
		same = (&sh[DIFF_W-1:SAMPLE_W-1]) || (~|sh[DIFF_W-1:SAMPLE_W-1]);
		if (same) begin
			return sh[SAMPLE_W-1:0];
		end else if (sh[DIFF_W-1]) begin
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	endfunction

endpackage

[src/rtpf_if.sv]
// Input channel: one sample with its cutoff and resonance per transfer.
interface rtpf_in_if;
	logic                 valid;
	logic                 ready;
	rtpf_pkg::sample_t    sample_in;
	rtpf_pkg::coeff_t     cutoff_coeff;
	rtpf_pkg::res_t       resonance;

	modport source (output valid, output sample_in, output cutoff_coeff, output resonance,
		input ready);
	modport sink (input valid, input sample_in, input cutoff_coeff, input resonance,
		output ready);
endinterface

// Output channel: one filtered sample per transfer.
interface rtpf_out_if;
	logic                 valid;
	logic                 ready;
	rtpf_pkg::sample_t    sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

[src/rtpf_mul.sv]
module rtpf_mul (
	input  logic             clk,
	input  logic             en,
	input  rtpf_pkg::mul_a_t a,
	input  rtpf_pkg::mul_b_t b,
	output rtpf_pkg::prod_t  prod_q
);
	import rtpf_pkg::*;

	prod_t prod;

	// Full-width signed product, registered for the next step.
	assign prod = a * b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod;
		end
	end

endmodule

[src/rtpf_ctrl.sv]
module rtpf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	output logic            in_ready,
	output rtpf_pkg::ctrl_t ctrl
);
	import rtpf_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_FB = 8'b0000_0010,
		ST_MUL_BP = 8'b0000_0100,
		ST_MUL_T  = 8'b0000_1000,
		ST_UPD1   = 8'b0001_0000,
		ST_MUL_D  = 8'b0010_0000,
		ST_UPD2   = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_e_t;

	state_e_t state_q;
	state_e_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// Step strobes decoded from the current state.
	always_comb begin
		ctrl        = '0;
		ctrl.load   = (state_q == ST_IDLE) && in_valid;
		ctrl.mul_fb = (state_q == ST_MUL_FB);
		ctrl.mul_bp = (state_q == ST_MUL_BP);
		ctrl.mul_t  = (state_q == ST_MUL_T);
		ctrl.upd1   = (state_q == ST_UPD1);
		ctrl.mul_d  = (state_q == ST_MUL_D);
		ctrl.upd2   = (state_q == ST_UPD2);
		ctrl.fin    = (state_q == ST_OUT) && out_free;
	end

	// Fixed walk through the steps; the last one waits for a free output register.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_MUL_FB;
			ST_MUL_FB: state_nxt = ST_MUL_BP;
			ST_MUL_BP: state_nxt = ST_MUL_T;
			ST_MUL_T:  state_nxt = ST_UPD1;
			ST_UPD1:   state_nxt = ST_MUL_D;
			ST_MUL_D:  state_nxt = ST_UPD2;
			ST_UPD2:   state_nxt = ST_OUT;
			ST_OUT:    if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[src/rtpf_dp.sv]
module rtpf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rtpf_pkg::ctrl_t   ctrl,
	input  rtpf_pkg::sample_t sample_in,
	input  rtpf_pkg::coeff_t  cutoff_coeff,
	input  rtpf_pkg::res_t    resonance,
	input  rtpf_pkg::mode_t   mode,
	input  rtpf_pkg::prod_t   prod,
	output rtpf_pkg::mul_a_t  mul_a,
	output rtpf_pkg::mul_b_t  mul_b,
	output rtpf_pkg::sample_t y
);
	import rtpf_pkg::*;

	state_t x_q;
	coeff_t f_q;
	res_t   r_q;
	diff_t  hp_q;
	diff_t  bp_q;
	state_t s1_q;
	state_t s2_q;

	logic signed [PQ_W-1:0] pq;
	mul_a_t t;
	mul_b_t fb;
	mul_b_t one_minus_f;
	diff_t  d12;
	diff_t  xd;

	// Product scaled back by the coefficient fraction bits; the high bits give the floor.
	assign pq          = prod[PROD_W-1:CF_BITS];
	assign one_minus_f = MB_W'(ONE_Q) - MB_W'(f_q);
	assign fb          = MB_W'(r_q) + pq[MB_W-1:0];
	assign t           = MA_W'(hp_q) + pq[MA_W-1:0];
	assign d12         = DIFF_W'(s1_q) - DIFF_W'(s2_q);
	assign xd          = DIFF_W'(x_q) - DIFF_W'(s2_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (ctrl.mul_fb) begin
			mul_a = MA_W'(r_q);
			mul_b = one_minus_f;
		end else if (ctrl.mul_bp) begin
			mul_a = MA_W'(bp_q);
			mul_b = fb;
		end else if (ctrl.mul_t) begin
			mul_a = t;
			mul_b = MB_W'(f_q);
		end else if (ctrl.mul_d) begin
			mul_a = MA_W'(d12);
			mul_b = MB_W'(f_q);
		end
	end

	// Item capture and the high-pass and band-pass terms from the old state.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= STATE_W'(sample_in) <<< UP_SHIFT;
			f_q <= (cutoff_coeff > COEFF_MAX) ? COEFF_MAX : cutoff_coeff;
			r_q <= (resonance > RES_MAX) ? RES_MAX : resonance;
		end
		if (ctrl.mul_fb) begin
			hp_q <= DIFF_W'(x_q) - DIFF_W'(s1_q);
			bp_q <= d12;
		end
	end

	// Filter stages, updated with saturation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			if (ctrl.upd1) begin
				s1_q <= sat_state(SUM_W'(s1_q) + SUM_W'(pq));
			end
			if (ctrl.upd2) begin
				s2_q <= sat_state(SUM_W'(s2_q) + SUM_W'(pq));
			end
		end
	end

	// Output selection by mode.
	always_comb begin
		case (mode)
			MODE_LP:     y = to_sample(DIFF_W'(s2_q));
			MODE_HP:     y = to_sample(hp_q);
			MODE_BP:     y = to_sample(bp_q);
			MODE_ALT_LP: y = to_sample(DIFF_W'(s1_q));
			MODE_ALT_HP: y = to_sample(xd);
			default:     y = '0;
		endcase
	end

endmodule

[src/resonant_two_pole_filter_top.sv]
// Resonant two-pole filter.
// Input channel in_ch: one transfer carries a signed sample, the cutoff
// coefficient 2*sin(pi*freq/rate) and the resonance. Output channel out_ch:
// one filtered sample for every input transfer, in order.
// The mode register is written through mode_wr_en and mode_wr_data and picks
// low-pass, high-pass, band-pass, alternate low-pass or alternate high-pass;
// other codes give zero. Write it only while no item is in flight.
// The result is loaded into the output register in the last step, which waits
// until that register is free. Each item goes through the accept step, four
// passes through the single shared multiplier, the two stage updates and the
// output load.
// in_ch.ready is high only while the sequencer is idle.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and if it finishes before the receiver takes the earlier one
// the sequencer holds in its last step until the register frees.
// Reset clears both filter stages, the mode to low-pass and the output valid.
module resonant_two_pole_filter_top (
	input  logic               clk,
	input  logic               arst_n,
	rtpf_in_if.sink            in_ch,
	rtpf_out_if.source         out_ch,
	input  logic               mode_wr_en,
	input  rtpf_pkg::mode_t    mode_wr_data
);
	import rtpf_pkg::*;

	ctrl_t   ctrl;
	mode_t   mode_q;
	mul_a_t  mul_a;
	mul_b_t  mul_b;
	prod_t   prod_q;
	sample_t y;
	sample_t out_q;
	logic    out_valid_q;
	logic    out_free;

	assign out_free = !out_valid_q || out_ch.ready;

	rtpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.out_free (out_free),
		.in_ready (in_ch.ready),
		.ctrl     (ctrl)
	);

	rtpf_mul u_mul (
		.clk    (clk),
		.en     (ctrl.mul_fb || ctrl.mul_bp || ctrl.mul_t || ctrl.mul_d),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	rtpf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.sample_in    (in_ch.sample_in),
		.cutoff_coeff (in_ch.cutoff_coeff),
		.resonance    (in_ch.resonance),
		.mode         (mode_q),
		.prod         (prod_q),
		.mul_a        (mul_a),
		.mul_b        (mul_b),
		.y            (y)
	);

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LP;
		end else if (mode_wr_en) begin
			mode_q <= mode_wr_data;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register data.
	always_ff @(posedge clk) begin
		if (ctrl.fin) begin
			out_q <= y;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_q;

	// An accepted item closes the input; the check looks at the first and the last step of the computation.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready ##6 !in_ch.ready)
		else $error("input reopened while an item is in flight");

	// A result is written only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin |-> (!out_valid_q || out_ch.ready))
		else $error("pending result overwritten");

	// Loading a result makes it visible in the next cycle.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin |=> out_ch.valid)
		else $error("finished result not presented");

	// The sequencer never finishes while idle for input.
	a_fin_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin |-> !in_ch.ready)
		else $error("result finished in the idle step");

endmodule
